>>> hw/rtl/bipartite_bit_matrix_switch_defines.svh
// Assertion macros used by the checker of the bipartite bit matrix switch.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef BIPARTITE_BIT_MATRIX_SWITCH_DEFINES_SVH
`define BIPARTITE_BIT_MATRIX_SWITCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbms checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbms checker: next-cycle property failed");

`endif

>>> hw/rtl/bbms_pkg.sv
// Package of the bipartite bit matrix switch: sizes, types and operation codes.
// Depends on nothing; used by the address unit, bit memory and top level.
package bbms_pkg;

  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int Depth   = MaxRows * MaxCols;
  localparam int AddrW   = $clog2(Depth);
  localparam int RowW    = $clog2(MaxRows);
  localparam int ColW    = $clog2(MaxCols);
  localparam int NodeW   = 7;
  localparam int CntW    = 7;
  localparam int KindW   = 3;
  localparam int IdxW    = 2;
  localparam int ProdW   = AddrW + CntW;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [ColW-1:0]  col_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [NodeW-1:0] node_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam cnt_t CntReset = 7'd64;

  typedef enum logic [KindW-1:0] {
    KindSet    = 3'd0,
    KindRead   = 3'd1,
    KindFlip   = 3'd2,
    KindTest   = 3'd3,
    KindSwitch = 3'd4
  } kind_e;

  typedef enum logic [IdxW-1:0] {
    RegRows = 2'd0,
    RegCols = 2'd1
  } reg_e;

  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    logic  wdata;
  } mem_req_t;

endpackage

>>> hw/rtl/bbms_addr_unit.sv
// Shared address unit of the bit matrix: registers row * stride + column.
// Depends on bbms_pkg.
module bbms_addr_unit (
  input  logic           clk_i,
  input  logic           en_i,
  input  bbms_pkg::row_t row_i,
  input  bbms_pkg::col_t col_i,
  input  bbms_pkg::cnt_t stride_i,
  output bbms_pkg::addr_t addr_o
);

  bbms_pkg::prod_t sum;
  bbms_pkg::addr_t addr_q;

  assign sum = bbms_pkg::prod_t'(row_i) * bbms_pkg::prod_t'(stride_i)
             + bbms_pkg::prod_t'(col_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q <= bbms_pkg::addr_t'(sum);
    end
  end

  assign addr_o = addr_q;

endmodule

>>> hw/rtl/bbms_bit_mem.sv
// Single-ported bit memory holding the edge matrix, with registered read data.
// Depends on bbms_pkg.
module bbms_bit_mem (
  input  logic               clk_i,
  input  bbms_pkg::mem_req_t req_i,
  output logic               rd_data_o
);

  logic mem [bbms_pkg::Depth];
  logic rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/bipartite_bit_matrix_switch.sv
// Top level of the bipartite bit matrix switch: sequencer, registers and decode.
// Depends on bbms_pkg, bbms_addr_unit and bbms_bit_mem.
//
// After reset the block clears its 4096-bit matrix, one bit a cycle, and keeps
// busy high while it does so. An operation is taken when start is high and
// busy is low. Each matrix access passes the shared address unit, then the
// single-ported bit memory for a read, then a use or write step; a cycle test
// or switch makes such an access for each matrix cell it covers, and an
// operation with a range error or an unused kind goes straight to the done
// step. The result shows on done_o for exactly one cycle, the last busy cycle,
// and must be taken then; the receiver cannot stall. Configuration writes are
// always ready and should only be issued while the block is idle.
module bipartite_bit_matrix_switch (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [bbms_pkg::KindW-1:0] kind_i,
  input  bbms_pkg::node_t        node_a_i,
  input  bbms_pkg::node_t        node_b_i,
  input  bbms_pkg::node_t        node_c_i,
  input  bbms_pkg::node_t        node_d_i,
  input  logic                   edge_value_i,
  output logic                   done_o,
  output logic                   answer_bit_o,
  output logic                   range_error_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [bbms_pkg::IdxW-1:0] cfg_index_i,
  input  bbms_pkg::cnt_t         cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RD,
    S_USE,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [1:0]                   step_q, step_d;
  bbms_pkg::addr_t              clr_q, clr_d;
  logic                         ans_q, ans_d;
  logic                         err_q, err_d;
  bbms_pkg::cnt_t               rows_q, cols_q;

  logic [bbms_pkg::KindW-1:0]   kind_q;
  logic                         val_q;
  bbms_pkg::row_t               row_q [2];
  bbms_pkg::col_t               col_q [2];
  logic [2:0]                   bits_q;

  bbms_pkg::cnt_t               eff_rows, eff_cols;
  logic [bbms_pkg::CntW:0]      lim;
  logic                         accept, is_bit, is_cyc, swap, dec_err;
  bbms_pkg::node_t              u1, l1, u2, l2, v1, v2;
  logic                         cyc_kind_q, write_kind_q, read_kind_q;
  bbms_pkg::addr_t              addr;
  bbms_pkg::mem_req_t           mem_req;
  logic                         rd_data;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (rows_q == '0) begin
      eff_rows = bbms_pkg::cnt_t'(1);
    end else if (int'(rows_q) > bbms_pkg::MaxRows) begin
      eff_rows = bbms_pkg::cnt_t'(bbms_pkg::MaxRows);
    end else begin
      eff_rows = rows_q;
    end
    if (cols_q == '0) begin
      eff_cols = bbms_pkg::cnt_t'(1);
    end else if (int'(cols_q) > bbms_pkg::MaxCols) begin
      eff_cols = bbms_pkg::cnt_t'(bbms_pkg::MaxCols);
    end else begin
      eff_cols = cols_q;
    end
  end

  // Decode of the offered operation, including label rotation and range checks.
  always_comb begin
    is_bit = (kind_i == bbms_pkg::KindSet) || (kind_i == bbms_pkg::KindRead) ||
             (kind_i == bbms_pkg::KindFlip);
    is_cyc = (kind_i == bbms_pkg::KindTest) || (kind_i == bbms_pkg::KindSwitch);
    swap   = node_a_i > node_b_i;
    u1     = swap ? node_b_i : node_a_i;
    l1     = swap ? node_c_i : node_b_i;
    u2     = swap ? node_d_i : node_c_i;
    l2     = swap ? node_a_i : node_d_i;
    lim    = {1'b0, eff_rows} + {1'b0, eff_cols};
    v1     = l1 - eff_rows;
    v2     = l2 - eff_rows;
    if (is_bit) begin
      dec_err = (node_a_i >= eff_rows) || (node_b_i >= eff_cols);
    end else if (is_cyc) begin
      dec_err = (u1 >= eff_rows) || (u2 >= eff_rows) ||
                (l1 < eff_rows) || (l2 < eff_rows) ||
                ({1'b0, l1} >= lim) || ({1'b0, l2} >= lim);
    end else begin
      dec_err = 1'b0;
    end
  end

  assign cyc_kind_q   = (kind_q == bbms_pkg::KindTest) || (kind_q == bbms_pkg::KindSwitch);
  assign write_kind_q = (kind_q == bbms_pkg::KindSet) || (kind_q == bbms_pkg::KindFlip) ||
                        (kind_q == bbms_pkg::KindSwitch);
  assign read_kind_q  = (kind_q != bbms_pkg::KindSet);

  bbms_addr_unit u_addr (
    .clk_i   (clk_i),
    .en_i    (state_q == S_ADDR),
    .row_i   (row_q[step_q[1]]),
    .col_i   (col_q[step_q[0]]),
    .stride_i(eff_cols),
    .addr_o  (addr)
  );

  always_comb begin
    mem_req = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_q;
        mem_req.wdata = 1'b0;
      end
      S_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = addr;
      end
      S_USE: begin
        mem_req.we    = write_kind_q;
        mem_req.addr  = addr;
        mem_req.wdata = (kind_q == bbms_pkg::KindSet) ? val_q : !rd_data;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  bbms_bit_mem u_mem (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    ans_d   = ans_q;
    err_d   = err_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == bbms_pkg::addr_t'(bbms_pkg::Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          step_d = 2'd0;
          ans_d  = 1'b0;
          err_d  = dec_err;
          if (dec_err || !(is_bit || is_cyc)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        state_d = read_kind_q ? S_RD : S_USE;
      end
      S_RD: begin
        state_d = S_USE;
      end
      S_USE: begin
        if (cyc_kind_q && (step_q != 2'd3)) begin
          step_d  = step_q + 2'd1;
          state_d = S_ADDR;
        end else begin
          state_d = S_DONE;
          if (kind_q == bbms_pkg::KindRead) begin
            ans_d = rd_data;
          end else if (kind_q == bbms_pkg::KindTest) begin
            ans_d = (bits_q[0] == rd_data) && (bits_q[1] == bits_q[2]) &&
                    (bits_q[0] != bits_q[1]);
          end else begin
            ans_d = 1'b0;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      step_q  <= 2'd0;
      clr_q   <= '0;
      ans_q   <= 1'b0;
      err_q   <= 1'b0;
      rows_q  <= bbms_pkg::CntReset;
      cols_q  <= bbms_pkg::CntReset;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      ans_q   <= ans_d;
      err_q   <= err_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bbms_pkg::RegRows: rows_q <= cfg_data_i;
          bbms_pkg::RegCols: cols_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      val_q    <= edge_value_i;
      if (is_cyc) begin
        row_q[0] <= bbms_pkg::row_t'(u1);
        row_q[1] <= bbms_pkg::row_t'(u2);
        col_q[0] <= bbms_pkg::col_t'(v1);
        col_q[1] <= bbms_pkg::col_t'(v2);
      end else begin
        row_q[0] <= bbms_pkg::row_t'(node_a_i);
        row_q[1] <= bbms_pkg::row_t'(node_a_i);
        col_q[0] <= bbms_pkg::col_t'(node_b_i);
        col_q[1] <= bbms_pkg::col_t'(node_b_i);
      end
    end
    if ((state_q == S_USE) && (step_q != 2'd3)) begin
      bits_q[step_q] <= rd_data;
    end
  end

  assign done_o        = (state_q == S_DONE);
  assign answer_bit_o  = ans_q;
  assign range_error_o = err_q;

endmodule

>>> hw/rtl/bbms_checker.sv
// Port-level checker of the bipartite bit matrix switch, bound to the top level.
// Depends on bipartite_bit_matrix_switch_defines.svh and the top-level ports.
`include "bipartite_bit_matrix_switch_defines.svh"

module bbms_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic answer_bit_o,
  input logic range_error_o
);

  `BBMS_ASSERT_NOW(a_done_while_busy, done_o, busy)
  `BBMS_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `BBMS_ASSERT_NEXT(a_done_single_cycle, done_o, !done_o)
  `BBMS_ASSERT_NOW(a_no_answer_on_error, done_o && answer_bit_o, !range_error_o)

endmodule

bind bipartite_bit_matrix_switch bbms_checker u_bbms_checker (.*);

>>> sim/bipartite_bit_matrix_switch_test.sv
// Self-checking testbench of the bipartite bit matrix switch: a directed table, then random
// operations over several matrix sizes, checked by the table or a local bit-matrix model.
// Depends on bbms_pkg and bipartite_bit_matrix_switch; needs nothing else.
module bipartite_bit_matrix_switch_test;

  typedef logic [bbms_pkg::KindW-1:0] kind_t;
  typedef logic [bbms_pkg::IdxW-1:0]  idx_t;

  localparam kind_t KindSpareA = 3'd5;
  localparam kind_t KindSpareC = 3'd7;
  localparam idx_t  RegSpare   = 2'd3;
  localparam bit IsOp  = 1'b0;
  localparam bit IsCfg = 1'b1;
  localparam int NumPhases = 8;
  localparam int PhaseOps  = 80;

  typedef struct {
    bit              is_cfg;
    idx_t            cfg_index;
    bbms_pkg::cnt_t  cfg_value;
    kind_t           kind;
    bbms_pkg::node_t a;
    bbms_pkg::node_t b;
    bbms_pkg::node_t c;
    bbms_pkg::node_t d;
    logic            val;
    bit              typed;
    logic            ans;
    logic            err;
  } step_t;

  typedef struct {
    logic ans;
    logic err;
  } answer_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  kind_t           kind_i;
  bbms_pkg::node_t node_a_i;
  bbms_pkg::node_t node_b_i;
  bbms_pkg::node_t node_c_i;
  bbms_pkg::node_t node_d_i;
  logic            edge_value_i;
  logic            done_o;
  logic            answer_bit_o;
  logic            range_error_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  idx_t            cfg_index_i;
  bbms_pkg::cnt_t  cfg_data_i;

  logic           edge_copy [bbms_pkg::Depth];
  bbms_pkg::cnt_t rows_copy;
  bbms_pkg::cnt_t cols_copy;
  answer_t        pending_answers [$];
  step_t          directed [$];
  int             errors;
  int             ops_sent;
  int             switchable_seen;
  int             settings_used;

  bipartite_bit_matrix_switch i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .kind_i,
    .node_a_i,
    .node_b_i,
    .node_c_i,
    .node_d_i,
    .edge_value_i,
    .done_o,
    .answer_bit_o,
    .range_error_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int eff_count(bbms_pkg::cnt_t v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int cell_index(int r, int c, int stride);
    return (r * stride + c) % bbms_pkg::Depth;
  endfunction

  task automatic apply_graph_op(input kind_t kind, input bbms_pkg::node_t a,
                                input bbms_pkg::node_t b, input bbms_pkg::node_t c,
                                input bbms_pkg::node_t d, input logic val,
                                output logic ans, output logic err);
    int rows_eff;
    int cols_eff;
    int u1, l1, u2, l2, v1, v2;
    int k11, k12, k21, k22;
    rows_eff = eff_count(rows_copy, bbms_pkg::MaxRows);
    cols_eff = eff_count(cols_copy, bbms_pkg::MaxCols);
    ans = 1'b0;
    err = 1'b0;
    if (kind == bbms_pkg::KindSet || kind == bbms_pkg::KindRead ||
        kind == bbms_pkg::KindFlip) begin
      if (int'(a) >= rows_eff || int'(b) >= cols_eff) begin
        err = 1'b1;
      end else begin
        k11 = cell_index(int'(a), int'(b), cols_eff);
        if (kind == bbms_pkg::KindSet) edge_copy[k11] = val;
        else if (kind == bbms_pkg::KindRead) ans = edge_copy[k11];
        else edge_copy[k11] = ~edge_copy[k11];
      end
    end else if (kind == bbms_pkg::KindTest || kind == bbms_pkg::KindSwitch) begin
      if (a > b) begin
        u1 = int'(b); l1 = int'(c); u2 = int'(d); l2 = int'(a);
      end else begin
        u1 = int'(a); l1 = int'(b); u2 = int'(c); l2 = int'(d);
      end
      if (u1 >= rows_eff || u2 >= rows_eff || l1 < rows_eff || l2 < rows_eff ||
          l1 - rows_eff >= cols_eff || l2 - rows_eff >= cols_eff) begin
        err = 1'b1;
      end else begin
        v1 = l1 - rows_eff;
        v2 = l2 - rows_eff;
        k11 = cell_index(u1, v1, cols_eff);
        k12 = cell_index(u1, v2, cols_eff);
        k21 = cell_index(u2, v1, cols_eff);
        k22 = cell_index(u2, v2, cols_eff);
        if (kind == bbms_pkg::KindTest) begin
          ans = (edge_copy[k11] == edge_copy[k22] && edge_copy[k12] == edge_copy[k21] &&
                 edge_copy[k11] != edge_copy[k12]);
        end else begin
          edge_copy[k11] = ~edge_copy[k11];
          edge_copy[k12] = ~edge_copy[k12];
          edge_copy[k21] = ~edge_copy[k21];
          edge_copy[k22] = ~edge_copy[k22];
        end
      end
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_index(int n);
    if ($urandom_range(0, 1)) return $urandom_range(0, (n < 8 ? n : 8) - 1);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic run_op(input kind_t kind, input bbms_pkg::node_t a, input bbms_pkg::node_t b,
                        input bbms_pkg::node_t c, input bbms_pkg::node_t d, input logic val,
                        input bit typed, input logic typed_ans, input logic typed_err,
                        input int gap);
    answer_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= kind;
    node_a_i     <= a;
    node_b_i     <= b;
    node_c_i     <= c;
    node_d_i     <= d;
    edge_value_i <= val;
    do @(posedge clk_i); while (busy);
    apply_graph_op(kind, a, b, c, d, val, predicted.ans, predicted.err);
    if (kind == bbms_pkg::KindTest && predicted.ans) switchable_seen++;
    if (typed) begin
      predicted.ans = typed_ans;
      predicted.err = typed_err;
    end
    pending_answers = {pending_answers, predicted};
    ops_sent++;
  endtask

  task automatic wait_for_quiet(input int settle);
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_answers.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      errors++;
      pending_answers.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input idx_t index, input bbms_pkg::cnt_t value);
    cfg_index_i <= index;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == bbms_pkg::RegRows) rows_copy = value;
    else if (index == bbms_pkg::RegCols) cols_copy = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic make_random_op(output kind_t kind, output bbms_pkg::node_t a,
                                output bbms_pkg::node_t b, output bbms_pkg::node_t c,
                                output bbms_pkg::node_t d, output logic val);
    int rows_eff;
    int cols_eff;
    int r;
    int u1, u2, l1, l2;
    rows_eff = eff_count(rows_copy, bbms_pkg::MaxRows);
    cols_eff = eff_count(cols_copy, bbms_pkg::MaxCols);
    r   = $urandom_range(0, 99);
    val = 1'($urandom_range(0, 1));
    a   = bbms_pkg::node_t'($urandom_range(0, 127));
    b   = bbms_pkg::node_t'($urandom_range(0, 127));
    c   = bbms_pkg::node_t'($urandom_range(0, 127));
    d   = bbms_pkg::node_t'($urandom_range(0, 127));
    if (r < 15) begin
      kind = kind_t'($urandom_range(0, 7));
    end else if (r < 50) begin
      case ($urandom_range(0, 2))
        0:       kind = bbms_pkg::KindSet;
        1:       kind = bbms_pkg::KindRead;
        default: kind = bbms_pkg::KindFlip;
      endcase
      a = bbms_pkg::node_t'(pick_index(rows_eff));
      b = bbms_pkg::node_t'(pick_index(cols_eff));
    end else begin
      kind = ($urandom_range(0, 4) < 3) ? bbms_pkg::KindTest : bbms_pkg::KindSwitch;
      u1 = pick_index(rows_eff);
      u2 = pick_index(rows_eff);
      l1 = pick_index(cols_eff) + rows_eff;
      l2 = pick_index(cols_eff) + rows_eff;
      if ($urandom_range(0, 1)) begin
        a = bbms_pkg::node_t'(l2);
        b = bbms_pkg::node_t'(u1);
        c = bbms_pkg::node_t'(l1);
        d = bbms_pkg::node_t'(u2);
      end else begin
        a = bbms_pkg::node_t'(u1);
        b = bbms_pkg::node_t'(l1);
        c = bbms_pkg::node_t'(u2);
        d = bbms_pkg::node_t'(l2);
      end
      if (r >= 95) begin
        case ($urandom_range(0, 3))
          0:       a = bbms_pkg::node_t'($urandom_range(0, 127));
          1:       b = bbms_pkg::node_t'($urandom_range(0, 127));
          2:       c = bbms_pkg::node_t'($urandom_range(0, 127));
          default: d = bbms_pkg::node_t'($urandom_range(0, 127));
        endcase
      end
    end
  endtask

  always @(posedge clk_i) begin
    answer_t exp;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("result with no expectation: answer_bit %0b, range_error %0b",
               answer_bit_o, range_error_o);
        errors++;
      end else begin
        exp = pending_answers.pop_front();
        if (answer_bit_o !== exp.ans) begin
          $error("answer_bit: expected %0b, actual %0b", exp.ans, answer_bit_o);
          errors++;
        end
        if (range_error_o !== exp.err) begin
          $error("range_error: expected %0b, actual %0b", exp.err, range_error_o);
          errors++;
        end
      end
    end
  end

  initial begin
    kind_t           kind;
    bbms_pkg::node_t a, b, c, d;
    logic            val;
    bbms_pkg::cnt_t  rows_value;
    bbms_pkg::cnt_t  cols_value;
    bit              quiet;
    int              phase_rows [NumPhases];
    int              phase_cols [NumPhases];

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    kind_i       <= bbms_pkg::KindSet;
    node_a_i     <= '0;
    node_b_i     <= '0;
    node_c_i     <= '0;
    node_d_i     <= '0;
    edge_value_i <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= bbms_pkg::RegRows;
    cfg_data_i   <= '0;
    errors          = 0;
    ops_sent        = 0;
    switchable_seen = 0;
    settings_used   = 1;
    rows_copy = bbms_pkg::CntReset;
    cols_copy = bbms_pkg::CntReset;
    foreach (edge_copy[i]) edge_copy[i] = 1'b0;
    phase_rows = '{64, 1, 0, 127, 2, 5, 64, 8};
    phase_cols = '{64, 1, 127, 0, 3, 7, 2, 64};

    directed = '{
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   0,   0,   0,   0,   0, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   63,  63,  0,   0,   0, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    64,  0,   0,   0,   1, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   0,   64,  0,   0,   0, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindFlip,   127, 127, 127, 127, 1, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    0,   0,   0,   0,   1, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   0,   0,   0,   0,   0, 1, 1, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    63,  63,  0,   0,   1, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   63,  63,  0,   0,   0, 1, 1, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindFlip,   63,  63,  0,   0,   0, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   63,  63,  0,   0,   0, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    1,   1,   0,   0,   1, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindTest,   0,   64,  1,   65,  0, 1, 1, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSwitch, 0,   64,  1,   65,  0, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindTest,   65,  0,   64,  1,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   0,   1,   0,   0,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindTest,   64,  100, 1,   65,  0, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSwitch, 0,   5,   1,   65,  0, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   KindSpareA,           127, 127, 127, 127, 1, 1, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   KindSpareC,           0,   0,   0,   0,   0, 1, 0, 0},
      '{IsCfg, bbms_pkg::RegRows, 4,   bbms_pkg::KindSet,    0,   0,   0,   0,   0, 0, 0, 0},
      '{IsCfg, bbms_pkg::RegCols, 4,   bbms_pkg::KindSet,    0,   0,   0,   0,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindTest,   0,   8,   1,   4,   0, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSwitch, 0,   4,   0,   5,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   1,   0,   0,   0,   0, 0, 0, 0},
      '{IsCfg, RegSpare,          127, bbms_pkg::KindSet,    0,   0,   0,   0,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   1,   1,   0,   0,   0, 0, 0, 0},
      '{IsCfg, bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    0,   0,   0,   0,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindSet,    1,   0,   0,   0,   1, 1, 0, 1},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindFlip,   0,   3,   0,   0,   0, 0, 0, 0},
      '{IsCfg, bbms_pkg::RegCols, 127, bbms_pkg::KindSet,    0,   0,   0,   0,   0, 0, 0, 0},
      '{IsOp,  bbms_pkg::RegRows, 0,   bbms_pkg::KindRead,   0,   63,  0,   0,   0, 0, 0, 0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_for_quiet(4);
        write_reg(directed[i].cfg_index, directed[i].cfg_value);
        settings_used++;
      end else begin
        run_op(directed[i].kind, directed[i].a, directed[i].b, directed[i].c,
               directed[i].d, directed[i].val, directed[i].typed, directed[i].ans,
               directed[i].err, pick_gap(1'b0));
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      rows_value = (phase >= 6) ? bbms_pkg::cnt_t'($urandom_range(0, 127))
                                : bbms_pkg::cnt_t'(phase_rows[phase]);
      cols_value = (phase >= 6) ? bbms_pkg::cnt_t'($urandom_range(0, 127))
                                : bbms_pkg::cnt_t'(phase_cols[phase]);
      wait_for_quiet(4);
      write_reg(bbms_pkg::RegRows, rows_value);
      write_reg(bbms_pkg::RegCols, cols_value);
      settings_used++;
      quiet = (phase == 3 || phase == 6);
      for (int n = 0; n < PhaseOps; n++) begin
        if (phase == 1 && n == PhaseOps / 2) wait_for_quiet(0);
        make_random_op(kind, a, b, c, d, val);
        run_op(kind, a, b, c, d, val, 1'b0, 1'b0, 1'b0, pick_gap(quiet));
      end
    end

    wait_for_quiet(20);
    $display("Sent %0d operations over %0d size settings, bursts and random gaps.",
             ops_sent, settings_used);
    $display("Cycle tests that found a switchable 4-cycle: %0d.", switchable_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bbms_pkg.sv
hw/rtl/bbms_addr_unit.sv
hw/rtl/bbms_bit_mem.sv
hw/rtl/bipartite_bit_matrix_switch.sv
hw/rtl/bbms_checker.sv
sim/bipartite_bit_matrix_switch_test.sv
